>>> rtl/sba_pkg.sv
// Shared constants, types and the helper function of the sector bitmap allocator.
package sba_pkg;

   localparam int MAP_ENTRIES   = 65536;
   localparam int WORD_BITS     = 32;
   localparam int NWORDS        = (MAP_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_W        = $clog2(NWORDS);
   localparam int BIT_W         = $clog2(WORD_BITS);
   localparam int SEC_W         = $clog2(MAP_ENTRIES);
   localparam int ADDR_W        = 21;
   localparam int COUNT_W       = 17;
   localparam int SECTOR_SCALE  = 29;
   localparam int RECIP_SHIFT   = 26;
   localparam int RECIP         = (1 << RECIP_SHIFT) / SECTOR_SCALE;
   localparam int RECIP_W       = $clog2(RECIP + 1);
   localparam int PROD_W        = ADDR_W + RECIP_W;
   localparam int QUOT_W        = PROD_W - RECIP_SHIFT;
   localparam int REM_W         = $clog2(2 * SECTOR_SCALE);
   localparam int RESET_SECTORS = 64;
   localparam int RESET_WORDS   = (RESET_SECTORS + WORD_BITS - 1) / WORD_BITS;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_MARK  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_FREE  = 2'd2;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_MULT = 2'd1,
      ST_RANGE    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]       cmd;
      status_type       status;
      logic [SEC_W-1:0] sector;
   } item_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RMW,
      BK_SCAN,
      BK_ALLOC_DONE
   } back_state_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } hit_type;

   // lowest clear bit of word among the bits enabled by mask
   function automatic hit_type first_clear(input logic [WORD_BITS-1:0] word,
                                           input logic [WORD_BITS-1:0] mask);
      hit_type h;
      h = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i] && mask[i]) begin
            h.found = 1'b1;
            h.idx   = BIT_W'(i);
         end
      end
      return h;
   endfunction

endpackage

>>> rtl/sba_front.sv
// Front end: accepts command words, divides the address by the sector size and classifies.
module sba_front import sba_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              clearing,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_cmd,
   input  logic [ADDR_W-1:0] req_sector_addr,
   input  logic              q_full,
   output logic              q_push,
   output item_type          q_item
);

   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_cmd_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [PROD_W-1:0] s1_prod_ff;

   logic              advance;
   logic              accept;
   logic [QUOT_W-1:0] quot;
   logic [QUOT_W-1:0] quot_c;
   logic [ADDR_W:0]   times;
   logic [ADDR_W:0]   diff;
   logic [REM_W-1:0]  rem;
   logic              exact;
   logic              in_range;
   logic [SEC_W-1:0]  sec;
   logic              known_cmd;

   assign advance  = !s1_valid_ff || !q_full;
   assign req_full = clearing || !advance;
   assign accept   = req_push && !req_full;
   assign q_push   = s1_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_addr_ff <= req_sector_addr;
         s1_prod_ff <= PROD_W'(req_sector_addr) * PROD_W'(RECIP);
      end
   end

   // quotient may be one low: correct with a single compare and subtract
   always_comb begin
      quot     = s1_prod_ff[PROD_W-1:RECIP_SHIFT];
      times    = (ADDR_W+1)'(quot) * (ADDR_W+1)'(SECTOR_SCALE);
      diff     = {1'b0, s1_addr_ff} - times;
      rem      = diff[REM_W-1:0];
      quot_c   = quot + QUOT_W'(rem >= REM_W'(SECTOR_SCALE));
      exact    = (rem == '0) || (rem == REM_W'(SECTOR_SCALE));
      in_range = 32'(quot_c) < 32'(MAP_ENTRIES);
      sec      = quot_c[SEC_W-1:0];
      known_cmd = (s1_cmd_ff == CMD_MARK) || (s1_cmd_ff == CMD_ALLOC) ||
                  (s1_cmd_ff == CMD_FREE);

      q_item.cmd = s1_cmd_ff;
      priority if (!known_cmd) begin
         q_item.status = ST_OK;
      end else if (!exact) begin
         q_item.status = ST_NOT_MULT;
      end else if (!in_range) begin
         q_item.status = ST_RANGE;
      end else begin
         q_item.status = ST_OK;
      end

      // allocate carries the first sector to search
      if (s1_cmd_ff == CMD_ALLOC) begin
         q_item.sector = (sec == SEC_W'(MAP_ENTRIES - 1)) ? SEC_W'(1) : sec + SEC_W'(1);
      end else begin
         q_item.sector = sec;
      end
   end

endmodule

>>> rtl/sba_queue.sv
// Short queue of classified commands between front and back.
module sba_queue import sba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type head,
   output logic     empty
);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;

   assign full    = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/sba_back.sv
// Back end: bitmap memory, used-sector counter, mark/free/allocate sequencer and result word.
module sba_back import sba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  item_type           q_item,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [ADDR_W-1:0]  rsp_alloc_addr,
   output logic [COUNT_W-1:0] rsp_used_count,
   output status_type         rsp_status
);

   logic [WORD_BITS-1:0] map_mem [NWORDS];
   logic [WORD_BITS-1:0] rd_word_ff;

   back_state_type       state_ff, state_in;
   logic [WORD_W-1:0]    clear_idx_ff, clear_idx_in;
   logic [1:0]           cmd_ff, cmd_in;
   logic [SEC_W-1:0]     sector_ff, sector_in;
   logic [WORD_W-1:0]    scan_word_ff, scan_word_in;
   logic                 visited_ff, visited_in;
   logic [SEC_W-1:0]     found_sector_ff, found_sector_in;
   logic [WORD_BITS-1:0] new_word_ff, new_word_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]    out_alloc_ff, out_alloc_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;
   status_type           out_status_ff, out_status_in;

   logic                 mem_we;
   logic [WORD_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_W-1:0]    mem_raddr;
   logic                 out_load;

   logic                 start;
   logic                 head_rmw;
   logic                 head_alloc;
   logic [WORD_W-1:0]    start_word;
   logic [WORD_BITS-1:0] lo_mask;
   logic [WORD_BITS-1:0] scan_mask;
   logic                 at_start;
   logic                 last_word;
   logic [WORD_W-1:0]    next_word;
   logic [WORD_BITS-1:0] sector_bit;
   hit_type              hit;

   always_comb begin
      start      = (state_ff == BK_IDLE) && !q_empty && !out_valid_ff;
      head_rmw   = (q_item.status == ST_OK) &&
                   ((q_item.cmd == CMD_MARK) || (q_item.cmd == CMD_FREE));
      head_alloc = (q_item.status == ST_OK) && (q_item.cmd == CMD_ALLOC);

      start_word = sector_ff[SEC_W-1:BIT_W];
      sector_bit = WORD_BITS'(1) << sector_ff[BIT_W-1:0];
      lo_mask    = sector_bit - WORD_BITS'(1);
      at_start   = scan_word_ff == start_word;
      last_word  = at_start && visited_ff;
      next_word  = (scan_word_ff == WORD_W'(NWORDS - 1)) ? '0 : scan_word_ff + WORD_W'(1);

      // first visit of the start word looks at and above the start bit, the
      // return visit below it; sector zero is never handed out
      scan_mask = '1;
      if (at_start) begin
         scan_mask = visited_ff ? lo_mask : ~lo_mask;
      end
      if (scan_word_ff == '0) begin
         scan_mask[0] = 1'b0;
      end
      hit = first_clear(rd_word_ff, scan_mask);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clear_idx_ff == WORD_W'(NWORDS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (start) begin
               priority if (head_rmw) begin
                  state_in = BK_RMW;
               end else if (head_alloc) begin
                  state_in = BK_SCAN;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_RMW: begin
            state_in = BK_IDLE;
         end
         BK_SCAN: begin
            priority if (hit.found) begin
               state_in = BK_ALLOC_DONE;
            end else if (last_word) begin
               state_in = BK_IDLE;
            end else begin
               state_in = BK_SCAN;
            end
         end
         BK_ALLOC_DONE: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop           = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      mem_wdata       = '0;
      mem_raddr       = scan_word_ff;
      out_load        = 1'b0;
      out_alloc_in    = '0;
      out_status_in   = ST_OK;
      clear_idx_in    = clear_idx_ff;
      cmd_in          = cmd_ff;
      sector_in       = sector_ff;
      scan_word_in    = scan_word_ff;
      visited_in      = visited_ff;
      found_sector_in = found_sector_ff;
      new_word_in     = new_word_ff;
      count_in        = count_ff;

      unique case (state_ff)
         BK_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_idx_ff;
            mem_wdata    = (32'(clear_idx_ff) < 32'(RESET_WORDS)) ? '1 : '0;
            clear_idx_in = clear_idx_ff + WORD_W'(1);
         end
         BK_IDLE: begin
            if (start) begin
               q_pop        = 1'b1;
               cmd_in       = q_item.cmd;
               sector_in    = q_item.sector;
               mem_raddr    = q_item.sector[SEC_W-1:BIT_W];
               scan_word_in = q_item.sector[SEC_W-1:BIT_W];
               visited_in   = 1'b0;
               if (!head_rmw && !head_alloc) begin
                  out_load      = 1'b1;
                  out_status_in = q_item.status;
               end
            end
         end
         BK_RMW: begin
            mem_we    = 1'b1;
            mem_waddr = start_word;
            if (cmd_ff == CMD_MARK) begin
               mem_wdata = rd_word_ff | sector_bit;
               count_in  = count_ff + COUNT_W'(1);
            end else begin
               mem_wdata = rd_word_ff & ~sector_bit;
               count_in  = count_ff - COUNT_W'(1);
            end
            out_load = 1'b1;
         end
         BK_SCAN: begin
            priority if (hit.found) begin
               found_sector_in = {scan_word_ff, hit.idx};
               new_word_in     = rd_word_ff | (WORD_BITS'(1) << hit.idx);
            end else if (last_word) begin
               out_load      = 1'b1;
               out_status_in = ST_FULL;
            end else begin
               mem_raddr    = next_word;
               scan_word_in = next_word;
               visited_in   = 1'b1;
            end
         end
         BK_ALLOC_DONE: begin
            mem_we       = 1'b1;
            mem_waddr    = found_sector_ff[SEC_W-1:BIT_W];
            mem_wdata    = new_word_ff;
            count_in     = count_ff + COUNT_W'(1);
            out_load     = 1'b1;
            out_alloc_in = ADDR_W'(found_sector_ff) * ADDR_W'(SECTOR_SCALE);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase

      out_count_in = count_in;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end else begin
         rd_word_ff <= map_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clear_idx_ff <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      sector_ff       <= sector_in;
      scan_word_ff    <= scan_word_in;
      visited_ff      <= visited_in;
      found_sector_ff <= found_sector_in;
      new_word_ff     <= new_word_in;
      if (out_load) begin
         out_alloc_ff  <= out_alloc_in;
         out_count_ff  <= out_count_in;
         out_status_ff <= out_status_in;
      end
   end

   assign clearing       = state_ff == BK_CLEAR;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_alloc_addr = out_alloc_ff;
   assign rsp_used_count = out_count_ff;
   assign rsp_status     = out_status_ff;

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SCAN) |-> !mem_we)
      else $error("bitmap written during scan");

   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !out_valid_ff)
      else $error("result word overwritten");

   a_count_with_result: assert property (@(posedge clock) disable iff (reset)
      !out_load |=> $stable(count_ff))
      else $error("counter moved without a result");

   a_full_no_addr: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == ST_FULL)) |-> (out_alloc_ff == '0))
      else $error("map-full result carries an address");

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CLEAR) |-> !q_pop)
      else $error("command taken during clearing pass");

endmodule

>>> rtl/sector_bitmap_allocator.sv
// Top level of the sector bitmap allocator: front end, command queue and back end.
// After reset the block runs a clearing pass over the 2048-word bitmap (full held high),
// leaving sectors 0 to 63 marked. A command word then passes through the front-end register
// (reciprocal multiply on the way in, remainder check on the way out), which holds while
// the queue is full, and waits in a four-deep queue.
// The back end, a single-port bitmap memory with registered read, takes one command at a
// time once the result word is free: an error status or an unused command gives its result
// straight from idle, mark and free read and then write back, and allocate scans 32-bit
// map words from the hint, at most 2049 word visits, then writes the found bit back; a full
// map gives a map-full status once the scan returns to the hint word.
module sector_bitmap_allocator import sba_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [1:0]                req_cmd,
   input  logic [ADDR_W-1:0]         req_sector_addr,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [ADDR_W-1:0]         rsp_alloc_addr,
   output logic signed [COUNT_W-1:0] rsp_used_count,
   output logic [1:0]                rsp_status
);

   logic               clearing;
   logic               q_push;
   item_type           q_push_item;
   logic               q_full;
   logic               q_pop;
   item_type           q_head;
   logic               q_empty;
   logic [COUNT_W-1:0] used_count;
   status_type         status;

   sba_front u_front (
      .clock           (clock),
      .reset           (reset),
      .clearing        (clearing),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_sector_addr (req_sector_addr),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   sba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   sba_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (q_head),
      .q_pop          (q_pop),
      .clearing       (clearing),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_alloc_addr (rsp_alloc_addr),
      .rsp_used_count (used_count),
      .rsp_status     (status)
   );

   assign rsp_used_count = signed'(used_count);
   assign rsp_status     = status;

endmodule

>>> tb/sector_bitmap_allocator_test.sv
// Self-checking testbench for the sector bitmap allocator: queued stimulus, predictor, scoreboard.
module sector_bitmap_allocator_test;
   import sba_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] addr;
   } command_word_type;

   typedef struct {
      logic [ADDR_W-1:0]         alloc_addr;
      logic signed [COUNT_W-1:0] used_count;
      status_type                status;
   } sector_reply_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [1:0]                req_cmd = CMD_MARK;
   logic [ADDR_W-1:0]         req_sector_addr = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic [ADDR_W-1:0]         rsp_alloc_addr;
   logic signed [COUNT_W-1:0] rsp_used_count;
   logic [1:0]                rsp_status;

   command_word_type commands_waiting[$];
   sector_reply_type replies_due[$];

   bit                sector_used [MAP_ENTRIES];
   logic [COUNT_W-1:0] used_sectors;

   int     items_accepted = 0;
   int     mismatches = 0;
   int     hold_left = 0;
   bit     hold_done = 1'b0;
   longint cycle_count = 0;
   longint cycle_budget = 0;
   longint cycle_limit = 64'd100000000;

   sector_bitmap_allocator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_cmd         (req_cmd),
      .req_sector_addr (req_sector_addr),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_alloc_addr  (rsp_alloc_addr),
      .rsp_used_count  (rsp_used_count),
      .rsp_status      (rsp_status)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic sector_reply_type apply_sector_command(input logic [1:0] cmd,
                                                             input logic [ADDR_W-1:0] addr);
      sector_reply_type r;
      int unsigned      sec;
      int unsigned      s;
      int unsigned      n;
      bit               found;
      r.alloc_addr = '0;
      r.status     = ST_OK;
      sec          = addr / SECTOR_SCALE;
      if (cmd != CMD_UNUSED) begin
         if (addr % SECTOR_SCALE != 0) begin
            r.status = ST_NOT_MULT;
         end else if (sec >= MAP_ENTRIES) begin
            r.status = ST_RANGE;
         end else if (cmd == CMD_MARK) begin
            sector_used[sec] = 1'b1;
            used_sectors     = used_sectors + 1'b1;
         end else if (cmd == CMD_FREE) begin
            sector_used[sec] = 1'b0;
            used_sectors     = used_sectors - 1'b1;
         end else begin
            s     = sec;
            n     = 0;
            found = 1'b0;
            while (!found && n < MAP_ENTRIES - 1) begin
               s = s + 1;
               if (s >= MAP_ENTRIES) s = 1;
               if (!sector_used[s]) found = 1'b1;
               n = n + 1;
            end
            if (found) begin
               sector_used[s] = 1'b1;
               used_sectors   = used_sectors + 1'b1;
               r.alloc_addr   = ADDR_W'(s * SECTOR_SCALE);
            end else begin
               r.status = ST_FULL;
            end
         end
      end
      r.used_count = used_sectors;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] sector_at(input int unsigned s);
      return ADDR_W'(s * SECTOR_SCALE);
   endfunction

   function automatic bit take_break();
      bit steady;
      steady = (items_accepted >= 700) && (items_accepted < 1000);
      return !steady && ($urandom_range(99) < 19);
   endfunction

   task automatic queue_command(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
      command_word_type c;
      c.cmd  = cmd;
      c.addr = addr;
      commands_waiting.push_back(c);
      cycle_budget += (cmd == CMD_ALLOC) ? 2080 : 16;
   endtask

   // driver
   always @(posedge clock) begin
      command_word_type c;
      bit               taken;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         taken = req_push && !req_full;
         if (taken) begin
            replies_due.push_back(apply_sector_command(req_cmd, req_sector_addr));
            items_accepted <= items_accepted + 1;
         end
         if (taken || !req_push) begin
            if (commands_waiting.size() != 0 && !take_break()) begin
               c = commands_waiting.pop_front();
               req_cmd         <= c.cmd;
               req_sector_addr <= c.addr;
               req_push        <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && items_accepted >= 200) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      sector_reply_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (replies_due.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("unexpected word: alloc_addr %0d used_count %0d status %0d",
                           rsp_alloc_addr, rsp_used_count, rsp_status);
            end else begin
               want = replies_due.pop_front();
               if (rsp_alloc_addr !== want.alloc_addr || rsp_used_count !== want.used_count ||
                   rsp_status !== want.status) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                              want.alloc_addr, want.used_count, want.status,
                              rsp_alloc_addr, rsp_used_count, rsp_status);
               end
            end
         end
         rsp_pop <= (hold_left == 0) && !take_break();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned       pick;
      int unsigned       sec;
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] addr;

      for (int i = 0; i < MAP_ENTRIES; i++) sector_used[i] = (i < RESET_SECTORS);
      used_sectors = '0;

      // directed
      queue_command(CMD_FREE, sector_at(0));
      queue_command(CMD_MARK, sector_at(0));
      queue_command(CMD_ALLOC, sector_at(0));
      queue_command(CMD_ALLOC, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_ALLOC, sector_at(MAP_ENTRIES - 2));
      queue_command(CMD_FREE, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_MARK, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_FREE, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_MARK, 21'd1);
      queue_command(CMD_ALLOC, 21'd28);
      queue_command(CMD_FREE, 21'h1FFFFF);
      queue_command(CMD_MARK, sector_at(MAP_ENTRIES));
      queue_command(CMD_ALLOC, sector_at(72315));
      queue_command(CMD_FREE, sector_at(70000));
      queue_command(CMD_UNUSED, 21'd0);
      queue_command(CMD_UNUSED, 21'h1FFFFF);
      queue_command(CMD_MARK, sector_at(100));
      queue_command(CMD_MARK, sector_at(100));
      queue_command(CMD_FREE, sector_at(100));
      queue_command(CMD_FREE, sector_at(100));
      queue_command(CMD_ALLOC, sector_at(63));
      queue_command(CMD_ALLOC, sector_at(1000));

      // random
      for (int i = 0; i < 1560; i++) begin
         pick = $urandom_range(99);
         if (pick < 36)      cmd = CMD_ALLOC;
         else if (pick < 64) cmd = CMD_MARK;
         else if (pick < 95) cmd = CMD_FREE;
         else                cmd = CMD_UNUSED;
         pick = $urandom_range(99);
         if (pick < 8) begin
            addr = ADDR_W'($urandom);
         end else begin
            if (pick < 14)      sec = $urandom_range(72315, MAP_ENTRIES);
            else if (pick < 20) sec = $urandom_range(MAP_ENTRIES - 1, MAP_ENTRIES - 40);
            else                sec = $urandom_range(1023);
            addr = sector_at(sec);
         end
         queue_command(cmd, addr);
      end

      // exercise the wrap-around cases
      queue_command(CMD_ALLOC, sector_at(0));
      queue_command(CMD_ALLOC, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_ALLOC, 21'd1234);
      queue_command(CMD_FREE, sector_at(5));
      queue_command(CMD_ALLOC, sector_at(65000));
      queue_command(CMD_FREE, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_ALLOC, sector_at(MAP_ENTRIES - 2));
      queue_command(CMD_FREE, sector_at(1));
      queue_command(CMD_ALLOC, sector_at(MAP_ENTRIES - 1));
      queue_command(CMD_MARK, sector_at(0));
      queue_command(CMD_FREE, sector_at(0));
      queue_command(CMD_ALLOC, sector_at(10));
      queue_command(CMD_MARK, sector_at(0));

      cycle_limit = 4 * cycle_budget + 4 * 2048 + 20000;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (commands_waiting.size() != 0 || req_push || replies_due.size() != 0)
         @(negedge clock);
      repeat (64) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
rtl/sba_pkg.sv
rtl/sba_front.sv
rtl/sba_queue.sv
rtl/sba_back.sv
rtl/sector_bitmap_allocator.sv
tb/sector_bitmap_allocator_test.sv
